@@ rtl/prime_field_log_exp_tables_assert.svh @@
// Assertion macros shared by the prime field log/exp table RTL.
// No dependencies; included by the files that carry assertions.
`ifndef PRIME_FIELD_LOG_EXP_TABLES_ASSERT_SVH
`define PRIME_FIELD_LOG_EXP_TABLES_ASSERT_SVH

// same-cycle implication
`define PFLET_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFLET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pflet_pkg.sv @@
// Shared types and constants for the prime field log/exp tables.
// No dependencies; imported by every module of the block.
package pflet_pkg;

	localparam int FIELD_W     = 12;
	localparam int KIND_W      = 2;
	localparam int STAT_W      = 2;
	localparam int TABLE_DEPTH = 1 << FIELD_W;
	localparam int CNT_W       = $clog2(FIELD_W);

	typedef logic [FIELD_W-1:0] field_t;

	localparam field_t ONE        = field_t'(1);
	localparam field_t ROOT_START = field_t'(2);
	localparam field_t RESET_P    = field_t'(2);

	typedef enum logic [KIND_W-1:0] {
		KIND_BUILD = 2'd0,
		KIND_LOG   = 2'd1,
		KIND_EXP   = 2'd2
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_BUILT = 2'd1,
		STAT_RANGE     = 2'd2
	} status_t;

	typedef struct packed {
		logic capture;
		logic cfg_wr;
		logic bld_init;
		logic ord_start;
		logic ord_upd;
		logic next_cand;
		logic set_g;
		logic fill_step;
		logic fill_upd;
		logic fix1;
		logic fix0;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic p_lt2;
		logic p_eq2;
		logic ord_more;
		logic cand_more;
		logic fill_more;
		logic mul_done;
	} dp_sts_t;

endpackage

@@ rtl/pflet_mulmod.sv @@
// Iterative modular multiplier: (a * b) mod p, one multiplier bit per cycle.
// Depends on pflet_pkg; requires b < p.
module pflet_mulmod import pflet_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  field_t a,
	input  field_t b,
	input  field_t p,
	output logic   done,
	output field_t result
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	field_t           a_q;
	field_t           b_q;
	field_t           r_q;

	logic [FIELD_W:0] pp;
	logic [FIELD_W:0] dbl;
	logic [FIELD_W:0] red1;
	logic [FIELD_W:0] sum;
	logic [FIELD_W:0] red2;

	always_comb begin
		pp   = {1'b0, p};
		dbl  = {r_q, 1'b0};
		red1 = (dbl >= pp) ? (dbl - pp) : dbl;
		sum  = red1 + (a_q[FIELD_W-1] ? {1'b0, b_q} : '0);
		red2 = (sum >= pp) ? (sum - pp) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			r_q   <= '0;
			cnt_q <= CNT_W'(FIELD_W - 1);
		end else if (busy_q) begin
			a_q   <= {a_q[FIELD_W-2:0], 1'b0};
			r_q   <= red2[FIELD_W-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

@@ rtl/pflet_dp.sv @@
// Datapath: modulus and build registers, order search and fill counters,
// log/exp memories and output register. Depends on pflet_pkg, pflet_mulmod.
module pflet_dp import pflet_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_sts_t             sts,
	input  field_t              prime_modulus,
	input  logic [KIND_W-1:0]   kind,
	input  field_t              operand,
	output field_t              value,
	output field_t              minus_one_exponent,
	output logic [STAT_W-1:0]   status
);

	field_t  p_q;
	logic    built_q;
	field_t  neg_q;

	kind_t   kind_q;
	field_t  opnd_q;
	field_t  cand_q;
	field_t  q_q;
	field_t  ord_q;
	field_t  g_q;
	field_t  n_q;
	field_t  i_q;
	field_t  log_rd_q;
	field_t  exp_rd_q;
	field_t  value_q;
	field_t  mexp_q;
	status_t status_q;

	field_t  log_mem [TABLE_DEPTH];
	field_t  exp_mem [TABLE_DEPTH];

	logic    log_we;
	field_t  log_wa;
	field_t  log_wd;
	logic    exp_we;
	field_t  exp_wa;
	field_t  exp_wd;

	logic    mul_start;
	field_t  mul_a;
	field_t  mul_b;
	logic    mul_done;
	field_t  mul_res;

	logic [FIELD_W:0] cand_inc;
	field_t  p_dec;
	field_t  value_d;
	status_t status_d;

	assign mul_start = cmd.ord_start | cmd.fill_step;
	assign mul_a     = cmd.ord_start ? q_q : n_q;
	assign mul_b     = cmd.ord_start ? cand_q : g_q;

	pflet_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.p      (p_q),
		.done   (mul_done),
		.result (mul_res)
	);

	assign p_dec    = p_q - ONE;
	assign cand_inc = {1'b0, cand_q} + 1'b1;

	always_comb begin
		sts.p_lt2     = p_q < RESET_P;
		sts.p_eq2     = p_q == RESET_P;
		sts.ord_more  = (q_q != ONE) && (ord_q < p_q);
		sts.cand_more = (cand_inc < {1'b0, p_q}) && (ord_q < p_dec);
		sts.fill_more = i_q < p_dec;
		sts.mul_done  = mul_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q     <= RESET_P;
			built_q <= 1'b0;
			neg_q   <= '0;
		end else begin
			if (cmd.cfg_wr) begin
				p_q     <= prime_modulus;
				built_q <= 1'b0;
			end
			if (cmd.bld_init) begin
				if (sts.p_eq2) begin
					neg_q <= ONE;
				end else if (sts.p_lt2) begin
					neg_q <= '0;
				end else begin
					neg_q <= p_dec >> 1;
				end
			end
			if (cmd.fix0) begin
				built_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind_t'(kind);
			opnd_q <= operand;
		end
		if (cmd.bld_init) begin
			cand_q <= ROOT_START;
			q_q    <= ROOT_START;
			ord_q  <= ONE;
			g_q    <= ONE;
			n_q    <= ONE;
			i_q    <= '0;
		end
		if (cmd.ord_upd) begin
			q_q   <= mul_res;
			ord_q <= ord_q + ONE;
		end
		if (cmd.next_cand) begin
			cand_q <= cand_inc[FIELD_W-1:0];
			q_q    <= cand_inc[FIELD_W-1:0];
			ord_q  <= ONE;
		end
		if (cmd.set_g) begin
			g_q <= cand_q;
		end
		if (cmd.fill_upd) begin
			n_q <= mul_res;
			i_q <= i_q + ONE;
		end
	end

	always_comb begin
		log_we = 1'b0;
		log_wa = '0;
		log_wd = '0;
		exp_we = 1'b0;
		exp_wa = '0;
		exp_wd = '0;
		if (cmd.fill_step) begin
			log_we = 1'b1;
			log_wa = n_q;
			log_wd = i_q;
			exp_we = 1'b1;
			exp_wa = i_q;
			exp_wd = n_q;
		end else if (cmd.fix1) begin
			log_we = 1'b1;
			log_wa = ONE;
			log_wd = p_dec;
			exp_we = 1'b1;
			exp_wa = p_dec;
			exp_wd = ONE;
		end else if (cmd.fix0) begin
			log_we = 1'b1;
			exp_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (log_we) begin
			log_mem[log_wa] <= log_wd;
		end
		if (cmd.capture) begin
			log_rd_q <= log_mem[operand];
		end
	end

	always_ff @(posedge clk) begin
		if (exp_we) begin
			exp_mem[exp_wa] <= exp_wd;
		end
		if (cmd.capture) begin
			exp_rd_q <= exp_mem[operand];
		end
	end

	always_comb begin
		value_d  = '0;
		status_d = STAT_OK;
		case (kind_q)
			KIND_BUILD: begin
				value_d = g_q;
			end
			KIND_LOG, KIND_EXP: begin
				if (!built_q) begin
					status_d = STAT_NOT_BUILT;
				end else if (opnd_q >= p_q) begin
					status_d = STAT_RANGE;
				end else begin
					value_d = (kind_q == KIND_LOG) ? log_rd_q : exp_rd_q;
				end
			end
			default: begin
				value_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			value_q  <= value_d;
			mexp_q   <= neg_q;
			status_q <= status_d;
		end
	end

	assign value              = value_q;
	assign minus_one_exponent = mexp_q;
	assign status             = status_q;

endmodule

@@ rtl/pflet_ctrl.sv @@
// Controller: sequences lookups, the primitive root search and the table fill.
// Depends on pflet_pkg and prime_field_log_exp_tables_assert.svh.
`include "prime_field_log_exp_tables_assert.svh"

module pflet_ctrl import pflet_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	output logic              out_valid,
	input  logic              out_stall,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	output dp_cmd_t           cmd,
	input  dp_sts_t           sts
);

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_BLD_INIT  = 8'b0000_0010,
		S_ORD_CHK   = 8'b0000_0100,
		S_ORD_WAIT  = 8'b0000_1000,
		S_FILL      = 8'b0001_0000,
		S_FILL_WAIT = 8'b0010_0000,
		S_FIX0      = 8'b0100_0000,
		S_RESP      = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_stall  = state_q != S_IDLE;
	assign cfg_ready = state_q == S_IDLE;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.cfg_wr    = cfg_valid && cfg_ready;
		cmd.capture   = accept;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (kind_t'(kind))
						KIND_BUILD: state_d = S_BLD_INIT;
						KIND_LOG:   state_d = S_RESP;
						KIND_EXP:   state_d = S_RESP;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_BLD_INIT: begin
				cmd.bld_init = 1'b1;
				if (sts.p_lt2) begin
					state_d = S_FIX0;
				end else if (sts.p_eq2) begin
					state_d = S_FILL;
				end else begin
					state_d = S_ORD_CHK;
				end
			end
			S_ORD_CHK: begin
				if (sts.ord_more) begin
					cmd.ord_start = 1'b1;
					state_d       = S_ORD_WAIT;
				end else if (sts.cand_more) begin
					cmd.next_cand = 1'b1;
				end else begin
					cmd.set_g = 1'b1;
					state_d   = S_FILL;
				end
			end
			S_ORD_WAIT: begin
				if (sts.mul_done) begin
					cmd.ord_upd = 1'b1;
					state_d     = S_ORD_CHK;
				end
			end
			S_FILL: begin
				if (sts.fill_more) begin
					cmd.fill_step = 1'b1;
					state_d       = S_FILL_WAIT;
				end else begin
					cmd.fix1 = 1'b1;
					state_d  = S_FIX0;
				end
			end
			S_FILL_WAIT: begin
				if (sts.mul_done) begin
					cmd.fill_upd = 1'b1;
					state_d      = S_FILL;
				end
			end
			S_FIX0: begin
				cmd.fix0 = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`PFLET_ASSERT_IMPL(a_mul_done_in_wait, clk, arst_n, sts.mul_done, (state_q == S_ORD_WAIT) || (state_q == S_FILL_WAIT), "multiply-mod result with no step waiting")
	`PFLET_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, cmd.load_out, out_valid_q, "loaded result not presented")
	`PFLET_ASSERT_NEXT(a_lookup_to_resp, clk, arst_n, accept && ((kind == KIND_LOG) || (kind == KIND_EXP)), state_q == S_RESP, "lookup did not go to response")

endmodule

@@ rtl/prime_field_log_exp_tables.sv @@
// Discrete log/antilog tables over GF(p) for a configured modulus p (reset 2).
// A log or exp lookup reads both 4096-entry memories into registers in the
// accept cycle; the output register is loaded from them once it is free, and the
// next item is taken while that result waits. A build runs the smallest
// primitive root search (p above 2) and the table fill (p of 2 or more) on
// one iterative multiply-mod unit, one product per order step and per table
// entry. Writing prime_modulus clears the built mark.
module prime_field_log_exp_tables import pflet_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	input  field_t            operand,
	output logic              out_valid,
	input  logic              out_stall,
	output field_t            value,
	output field_t            minus_one_exponent,
	output logic [STAT_W-1:0] status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  field_t            prime_modulus
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	pflet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pflet_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.prime_modulus      (prime_modulus),
		.kind               (kind),
		.operand            (operand),
		.value              (value),
		.minus_one_exponent (minus_one_exponent),
		.status             (status)
	);

endmodule
